### hw/rtl/pfa_pkg.sv
package pfa_pkg;

    // default table depth
    localparam int NUM_PARTITIONS_DEF = 16;

    // field widths
    localparam int CMD_W   = 2;
    localparam int PIDX_W  = 4;
    localparam int SIZE_W  = 16;
    localparam int TOTAL_W = 20;
    localparam int MODE_W  = 2;
    localparam int COUNT_W = 5;

    // stream and register port widths
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // input beat layout, lowest bit first
    localparam int S_CMD_LO  = 0;
    localparam int S_PIDX_LO = S_CMD_LO + CMD_W;
    localparam int S_SIZE_LO = S_PIDX_LO + PIDX_W;

    // result beat layout, lowest bit first
    localparam int M_ALLOC_LO = 0;
    localparam int M_IDX_LO   = M_ALLOC_LO + 1;
    localparam int M_SIZE_LO  = M_IDX_LO + PIDX_W;
    localparam int M_FRAG_LO  = M_SIZE_LO + SIZE_W;
    localparam int M_TOTAL_LO = M_FRAG_LO + SIZE_W;

    // saturation point of the running fragment total
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(1048560);

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // placement policies
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_PART_COUNT = 1'b1;

    // reset value of the partition count register
    localparam logic [COUNT_W-1:0] PART_COUNT_RST = 5'd16;

    // controller to datapath
    typedef struct packed {
        logic start;   // input beat taken
        logic step;    // read next table entry
        logic finish;  // commit and load the result register
    } pfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_alloc;  // beat at the input is an allocate request
        logic scan_end;  // every entry in use has been read
    } pfa_status_t;

endpackage

### hw/rtl/partition_fit_allocator_unit.sv
// channel   | ports                  | beat contents
// ----------+------------------------+------------------------------------------------
// request   | s_tvalid/s_tready/data | command, partition index, size (kB)
// result    | m_tvalid/m_tready/data | allocated, index, size, fragment, running total
// config    | apb psel ... pready    | fit mode at 0x0, partition count at 0x4
//
// an allocate scans min(partition_count, NUM_PARTITIONS) table entries before it commits;
// the scan reads one table entry per cycle through the table's
// single registered read port. load, restart and unused codes skip the scan and go to commit.
// reset is synchronous, active low, and empties the table and the total at once.
// a waiting result does not block the next request; a second result waits for the first.
module partition_fit_allocator_unit #(
    parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // [1:0] command, [5:2] partition_index, [21:6] size_kb, [23:22] zero
    input  logic [pfa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [0] allocated, [4:1] chosen_index, [20:5] chosen_size_kb,
    // [36:21] fragment_kb, [56:37] total_fragment_kb, [63:57] zero
    output logic [pfa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pfa_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [pfa_pkg::MODE_W-1:0]  fit_mode_reg;
    logic [pfa_pkg::COUNT_W-1:0] part_count_reg;
    logic                        cfg_wr;
    pfa_pkg::pfa_cmd_t           cmd;
    pfa_pkg::pfa_status_t        status;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg   <= pfa_pkg::FIT_FIRST;
            part_count_reg <= pfa_pkg::PART_COUNT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == pfa_pkg::REG_FIT_MODE) begin
                fit_mode_reg <= pwdata[pfa_pkg::MODE_W-1:0];
            end else begin
                part_count_reg <= pwdata[pfa_pkg::COUNT_W-1:0];
            end
        end
    end

    // read back
    always_comb begin
        case (paddr[2])
            pfa_pkg::REG_FIT_MODE:   prdata = pfa_pkg::CFG_DATA_W'(fit_mode_reg);
            pfa_pkg::REG_PART_COUNT: prdata = pfa_pkg::CFG_DATA_W'(part_count_reg);
            default:                 prdata = '0;
        endcase
    end

    pfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfa_dp #(
        .NUM_PARTITIONS (NUM_PARTITIONS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .fit_mode        (fit_mode_reg),
        .partition_count (part_count_reg),
        .cmd             (cmd),
        .status          (status),
        .m_tdata         (m_tdata)
    );

endmodule

### hw/rtl/pfa_ctrl.sv
module pfa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  pfa_pkg::pfa_status_t status,
    output pfa_pkg::pfa_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    // commands to the datapath
    always_comb begin
        cmd.start  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.step   = (state_reg == ST_SCAN) && !status.scan_end;
        cmd.finish = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    state_next = status.in_alloc ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (status.scan_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat valid: set on commit, dropped once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.finish) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTH
    // load, restart and unused codes go straight to the commit state
    a_short_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start && !status.in_alloc |=> state_reg == ST_DONE)
        else $error("non-allocate beat did not go to commit");

    // a finished scan always ends in the commit state
    a_scan_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && status.scan_end |=> state_reg == ST_DONE)
        else $error("scan did not finish into commit");

    // after a commit the result is shown and the input side is open again
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid_reg && s_tready)
        else $error("commit did not present a result");

    // a result only appears through a commit
    a_no_stray: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd.finish))
        else $error("result beat without commit");
`endif

endmodule

### hw/rtl/pfa_dp.sv
module pfa_dp #(
    parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [pfa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [pfa_pkg::MODE_W-1:0]       fit_mode,
    input  logic [pfa_pkg::COUNT_W-1:0]      partition_count,
    input  pfa_pkg::pfa_cmd_t                cmd,
    output pfa_pkg::pfa_status_t             status,
    output logic [pfa_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
    localparam int SW    = pfa_pkg::SIZE_W;
    localparam int TW    = pfa_pkg::TOTAL_W;

    // input beat fields
    logic [pfa_pkg::CMD_W-1:0]  in_cmd;
    logic [pfa_pkg::PIDX_W-1:0] in_pidx;
    logic [SW-1:0]              in_size;
    logic [IDX_W-1:0]           ld_addr;
    logic                       ld_ok;

    // table of loaded sizes and per-entry flags
    logic [SW-1:0]             orig_mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] orig_valid_reg;
    logic [NUM_PARTITIONS-1:0] used_reg;

    // scan state
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          lim;
    logic [IDX_W-1:0]          scan_addr;
    logic [SW-1:0]             rd_data_reg;
    logic                      rd_live_reg;
    logic [IDX_W-1:0]          rd_addr_reg;
    logic                      rd_pend_reg;
    logic [SW-1:0]             eff_size;
    logic                      take;

    // request and running choice
    logic [pfa_pkg::CMD_W-1:0] op_reg;
    logic [SW-1:0]             req_reg;
    logic                      found_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic [SW-1:0]             best_size_reg;

    // commit arithmetic
    logic [TW-1:0]             total_reg;
    logic [TW-1:0]             total_new;
    logic [SW-1:0]             frag;
    logic [TW:0]               sum;
    logic                      alloc_ok;
    logic [pfa_pkg::M_TDATA_W-1:0] out_reg;
    logic [pfa_pkg::M_TDATA_W-1:0] out_next;

    assign in_cmd  = s_tdata[pfa_pkg::S_CMD_LO +: pfa_pkg::CMD_W];
    assign in_pidx = s_tdata[pfa_pkg::S_PIDX_LO +: pfa_pkg::PIDX_W];
    assign in_size = s_tdata[pfa_pkg::S_SIZE_LO +: SW];
    assign ld_addr = IDX_W'(in_pidx);
    assign ld_ok   = 32'(in_pidx) < NUM_PARTITIONS;

    // entries in use, clipped to the table depth
    assign lim = (32'(partition_count) > NUM_PARTITIONS) ? CNT_W'(NUM_PARTITIONS)
                                                         : CNT_W'(partition_count);
    assign scan_addr = cnt_reg[IDX_W-1:0];

    assign status.in_alloc = (in_cmd == pfa_pkg::CMD_ALLOC);
    assign status.scan_end = (cnt_reg == lim);

    // remaining size of the entry just read: zero if never loaded or already taken
    assign eff_size = rd_live_reg ? rd_data_reg : '0;

    // fit compare, ties keep the lower index
    always_comb begin
        take = 1'b0;
        if (rd_pend_reg && (eff_size >= req_reg)) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (fit_mode == pfa_pkg::FIT_BEST) begin
                take = eff_size < best_size_reg;
            end else if (fit_mode == pfa_pkg::FIT_WORST) begin
                take = eff_size > best_size_reg;
            end
        end
    end

    // fragment and saturating total
    always_comb begin
        alloc_ok  = (op_reg == pfa_pkg::CMD_ALLOC) && found_reg;
        frag      = best_size_reg - req_reg;
        sum       = {1'b0, total_reg} + (TW + 1)'(frag);
        total_new = total_reg;
        if (alloc_ok) begin
            total_new = (sum > (TW + 1)'(pfa_pkg::TOTAL_MAX)) ? pfa_pkg::TOTAL_MAX
                                                              : sum[TW-1:0];
        end
    end

    // result beat
    always_comb begin
        out_next = '0;
        out_next[pfa_pkg::M_TOTAL_LO +: TW] = total_new;
        if (alloc_ok) begin
            out_next[pfa_pkg::M_ALLOC_LO]                = 1'b1;
            out_next[pfa_pkg::M_IDX_LO +: pfa_pkg::PIDX_W] = pfa_pkg::PIDX_W'(best_idx_reg);
            out_next[pfa_pkg::M_SIZE_LO +: SW]           = best_size_reg;
            out_next[pfa_pkg::M_FRAG_LO +: SW]           = frag;
        end
    end

    // size table: one write port for loads, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (cmd.start && (in_cmd == pfa_pkg::CMD_LOAD) && ld_ok) begin
            orig_mem[ld_addr] <= in_size;
        end
        if (cmd.step) begin
            rd_data_reg <= orig_mem[scan_addr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg  <= in_cmd;
            req_reg <= in_size;
        end
        if (cmd.step) begin
            rd_live_reg <= orig_valid_reg[scan_addr] && !used_reg[scan_addr];
            rd_addr_reg <= scan_addr;
        end
        if (take) begin
            best_idx_reg  <= rd_addr_reg;
            best_size_reg <= eff_size;
        end
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    // control state: flags, counter, total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orig_valid_reg <= '0;
            used_reg       <= '0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            total_reg      <= '0;
        end else begin
            rd_pend_reg <= cmd.step;
            if (cmd.step) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (take) begin
                found_reg <= 1'b1;
            end
            if (cmd.start) begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                if ((in_cmd == pfa_pkg::CMD_LOAD) && ld_ok) begin
                    orig_valid_reg[ld_addr] <= 1'b1;
                    used_reg[ld_addr]       <= 1'b0;
                end
                if (in_cmd == pfa_pkg::CMD_RESTART) begin
                    used_reg  <= '0;
                    total_reg <= '0;
                end
            end
            if (cmd.finish) begin
                total_reg <= total_new;
                if (alloc_ok) begin
                    used_reg[best_idx_reg] <= 1'b1;
                end
            end
        end
    end

    assign m_tdata = out_reg;

endmodule
